/* sv/rsrg_pkg.sv */
// Shared types, constants and state encoding for the replacement selection run generator.
package rsrg_pkg;

    localparam int SLOTS    = 8;
    localparam int KEY_BITS = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W   = $clog2(SLOTS + 1);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [15:0] key;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_key;
        logic        end_of_run;
        logic        done_res;
    } out_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                last;
    } work_t;

    typedef struct packed {
        logic  valid;
        work_t item;
    } queue_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_FLUSH,
        ST_MARK,
        ST_EMIT,
        ST_REPLAY,
        ST_DONE
    } back_state_t;

endpackage

/* sv/rsrg_front.sv */
// Input side: accepts transfers, trims keys and buffers them in a short queue.
module rsrg_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rsrg_pkg::in_item_t   s_data,
    output rsrg_pkg::queue_head_t head,
    input  logic                 pop
);
    import rsrg_pkg::*;

    work_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              do_pop;

    assign s_ready = (count_reg < QCNT_W'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg].key  <= s_data.key[KEY_BITS-1:0];
            mem_reg[wr_ptr_reg].last <= s_data.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* sv/rsrg_back.sv */
// Execution side: workspace, loser tree replay sequencer and output register.
module rsrg_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rsrg_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsrg_pkg::out_item_t   m_data
);
    import rsrg_pkg::*;

    back_state_t         state_reg, state_next;
    logic [KEY_BITS-1:0] slot_key_reg [SLOTS];
    logic                slot_tag_reg [SLOTS];
    logic                slot_empty_reg [SLOTS];
    logic [IDX_W-1:0]    tree_reg [SLOTS];
    logic [FILL_W-1:0]   fill_reg;
    logic                cur_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                last_reg;
    logic                flush_reg;
    logic [IDX_W-1:0]    w_reg;
    logic [IDX_W-1:0]    t_reg;
    logic [IDX_W-1:0]    q_idx_reg;
    logic [KEY_BITS-1:0] q_key_reg;
    logic                q_tag_reg;
    logic                q_empty_reg;
    out_item_t           out_reg;
    logic                out_valid_reg;

    logic                out_free;
    logic                out_load;
    logic                building;
    logic [IDX_W-1:0]    win;
    logic [IDX_W-1:0]    rd_idx;
    logic [KEY_BITS-1:0] rd_key;
    logic                rd_tag;
    logic                rd_empty;
    logic [IDX_W-1:0]    fill_slot;
    logic [IDX_W-1:0]    fill_t;
    logic [IDX_W-1:0]    w_t;
    logic                p_wins;
    logic [IDX_W-1:0]    t_half;

    function automatic logic [1:0] rank(input logic e, input logic tg, input logic cur);
        logic [1:0] r;
        if (e) begin
            r = 2'd2;
        end else begin
            r = (tg == cur) ? 2'd0 : 2'd1;
        end
        return r;
    endfunction

    function automatic logic beats(
        input logic [IDX_W-1:0] ai, input logic ae, input logic at, input logic [KEY_BITS-1:0] ak,
        input logic [IDX_W-1:0] bi, input logic be, input logic bt, input logic [KEY_BITS-1:0] bk,
        input logic bld, input logic cur);
        logic [1:0] ra;
        logic [1:0] rb;
        logic       res;
        ra = rank(ae, at, cur);
        rb = rank(be, bt, cur);
        if (bld && ai == '0) begin
            res = (bi != '0);
        end else if (bld && bi == '0) begin
            res = 1'b0;
        end else if (ra != rb) begin
            res = (ra < rb);
        end else begin
            res = (ak < bk);
        end
        return res;
    endfunction

    assign out_free  = !out_valid_reg || m_ready;
    assign out_load  = out_free && (state_reg == ST_MARK || state_reg == ST_EMIT ||
                                    state_reg == ST_DONE);
    assign building  = (fill_reg < FILL_W'(SLOTS));
    assign win       = tree_reg[0];
    assign fill_slot = IDX_W'(SLOTS - 1) - fill_reg[IDX_W-1:0];
    assign fill_t    = IDX_W'(((IDX_W+1)'(SLOTS) + {1'b0, fill_slot}) >> 1);
    assign w_t       = IDX_W'(((IDX_W+1)'(SLOTS) + {1'b0, w_reg}) >> 1);
    assign t_half    = t_reg >> 1;

    always_comb begin
        case (state_reg)
            ST_REPLAY:       rd_idx = tree_reg[t_reg];
            ST_MARK, ST_EMIT: rd_idx = w_reg;
            default:         rd_idx = win;
        endcase
    end

    assign rd_key   = slot_key_reg[rd_idx];
    assign rd_tag   = slot_tag_reg[rd_idx];
    assign rd_empty = slot_empty_reg[rd_idx];
    assign p_wins   = beats(rd_idx, rd_empty, rd_tag, rd_key,
                            q_idx_reg, q_empty_reg, q_tag_reg, q_key_reg, building, cur_reg);

    assign pop     = (state_reg == ST_IDLE) && head.valid;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    if (building) begin
                        state_next = ST_REPLAY;
                    end else if (!rd_empty) begin
                        state_next = (rd_tag != cur_reg) ? ST_MARK : ST_EMIT;
                    end else if (head.item.last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:   state_next = building ? ST_REPLAY : ST_FLUSH;
            ST_FLUSH: begin
                if (rd_empty) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = (rd_tag != cur_reg) ? ST_MARK : ST_EMIT;
                end
            end
            ST_MARK:  if (out_free) state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_REPLAY;
            ST_REPLAY: begin
                if (t_half == '0) begin
                    if (flush_reg) begin
                        state_next = ST_FLUSH;
                    end else if (last_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_key_reg[i]   <= '0;
                slot_tag_reg[i]   <= 1'b0;
                slot_empty_reg[i] <= 1'b1;
                tree_reg[i]       <= '0;
            end
            fill_reg      <= '0;
            cur_reg       <= 1'b0;
            last_reg      <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (head.valid) begin
                        key_reg  <= head.item.key;
                        last_reg <= head.item.last;
                        w_reg    <= win;
                        if (building) begin
                            slot_key_reg[fill_slot]   <= head.item.key;
                            slot_tag_reg[fill_slot]   <= cur_reg;
                            slot_empty_reg[fill_slot] <= 1'b0;
                            fill_reg    <= fill_reg + 1'b1;
                            q_idx_reg   <= fill_slot;
                            q_key_reg   <= head.item.key;
                            q_tag_reg   <= cur_reg;
                            q_empty_reg <= 1'b0;
                            t_reg       <= fill_t;
                        end
                    end
                end
                ST_PAD: begin
                    if (building) begin
                        slot_key_reg[fill_slot]   <= '0;
                        slot_tag_reg[fill_slot]   <= cur_reg;
                        slot_empty_reg[fill_slot] <= 1'b1;
                        fill_reg    <= fill_reg + 1'b1;
                        q_idx_reg   <= fill_slot;
                        q_key_reg   <= '0;
                        q_tag_reg   <= cur_reg;
                        q_empty_reg <= 1'b1;
                        t_reg       <= fill_t;
                    end else begin
                        flush_reg <= 1'b1;
                    end
                end
                ST_FLUSH: begin
                    w_reg <= win;
                end
                ST_MARK: begin
                    if (out_free) begin
                        out_reg.out_key    <= '0;
                        out_reg.end_of_run <= 1'b1;
                        out_reg.done_res   <= 1'b0;
                        out_valid_reg      <= 1'b1;
                        cur_reg            <= ~cur_reg;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_reg.out_key    <= 16'(rd_key);
                        out_reg.end_of_run <= 1'b0;
                        out_reg.done_res   <= 1'b0;
                        out_valid_reg      <= 1'b1;
                        q_idx_reg          <= w_reg;
                        t_reg              <= w_t;
                        if (flush_reg) begin
                            slot_key_reg[w_reg]   <= '0;
                            slot_empty_reg[w_reg] <= 1'b1;
                            q_key_reg             <= '0;
                            q_tag_reg             <= rd_tag;
                            q_empty_reg           <= 1'b1;
                        end else begin
                            slot_key_reg[w_reg]   <= key_reg;
                            slot_empty_reg[w_reg] <= 1'b0;
                            slot_tag_reg[w_reg]   <= (key_reg < rd_key) ? ~cur_reg : cur_reg;
                            q_key_reg             <= key_reg;
                            q_tag_reg             <= (key_reg < rd_key) ? ~cur_reg : cur_reg;
                            q_empty_reg           <= 1'b0;
                        end
                    end
                end
                ST_REPLAY: begin
                    if (p_wins) begin
                        tree_reg[t_reg] <= q_idx_reg;
                        q_idx_reg       <= rd_idx;
                        q_key_reg       <= rd_key;
                        q_tag_reg       <= rd_tag;
                        q_empty_reg     <= rd_empty;
                    end
                    t_reg <= t_half;
                    if (t_half == '0) begin
                        tree_reg[0] <= p_wins ? rd_idx : q_idx_reg;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_reg.out_key    <= '0;
                        out_reg.end_of_run <= 1'b1;
                        out_reg.done_res   <= 1'b1;
                        out_valid_reg      <= 1'b1;
                        for (int i = 0; i < SLOTS; i++) begin
                            slot_key_reg[i]   <= '0;
                            slot_tag_reg[i]   <= 1'b0;
                            slot_empty_reg[i] <= 1'b1;
                            tree_reg[i]       <= '0;
                        end
                        fill_reg  <= '0;
                        cur_reg   <= 1'b0;
                        last_reg  <= 1'b0;
                        flush_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* sv/replacement_selection_run_generator_core.sv */
// Top level of the replacement selection run generator.
// The block turns a stream of keys into sorted runs for an external sort.
// Keys arrive on the s_ channel, one key per transfer, with last on the final key.
// The first eight keys fill the workspace and produce no result. Each later key
// produces one record result, preceded by an end-of-run marker when the next run starts.
// After the last key the workspace is flushed and a marker with done_res set closes
// the final run; the block then starts a fresh input with the next key.
// Sequence: while the workspace fills, the back end takes a key and then runs the
// loser tree replay, one tree level per cycle. After that each key is also emitted,
// preceded by any marker, before the replay.
// On short input each unfilled slot is padded and replayed. The flush then starts,
// each flushed key is emitted and replayed, preceded by any marker, and the final
// marker closes the input.
// Results sit in an output register. A stalled receiver holds the back end at its next
// result; the two-entry input queue then fills and s_ready drops.
// Reset is synchronous and clears the workspace, the tree and all handshake state.
module replacement_selection_run_generator_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rsrg_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rsrg_pkg::out_item_t m_data
);
    import rsrg_pkg::*;

    queue_head_t head;
    logic        pop;

    rsrg_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .head    (head),
        .pop     (pop)
    );

    rsrg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_done_is_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.end_of_run)
        else $error("final result is not a marker");

    a_marker_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.end_of_run |-> m_data.out_key == '0)
        else $error("marker carries a nonzero key");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("queue popped while empty");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the replacement selection run generator core.
`timescale 1ns / 1ps

module tb_top;
    import rsrg_pkg::*;

    class run_scoreboard;
        bit [15:0] slot_key [SLOTS];
        bit        slot_tag [SLOTS];
        bit        slot_emp [SLOTS];
        int        tree     [SLOTS];
        int        fill;
        bit        cur_tag;
        out_item_t pending[$];
        int        errors;
        int        records;
        int        markers;
        int        files;

        function new();
            errors = 0;
            records = 0;
            markers = 0;
            files = 0;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < SLOTS; i++) begin
                slot_key[i] = '0;
                slot_tag[i] = 1'b0;
                slot_emp[i] = 1'b1;
                tree[i] = 0;
            end
            fill = 0;
            cur_tag = 1'b0;
        endfunction

        function int rank(int s);
            if (slot_emp[s]) return 2;
            return (slot_tag[s] == cur_tag) ? 0 : 1;
        endfunction

        function bit wins(int a, int b);
            bit building;
            building = fill < SLOTS;
            if (building && a == 0) return b != 0;
            if (building && b == 0) return 1'b0;
            if (rank(a) != rank(b)) return rank(a) < rank(b);
            return slot_key[a] < slot_key[b];
        endfunction

        function void replay(int q);
            int t;
            int p;
            t = (SLOTS + q) / 2;
            while (t > 0) begin
                p = tree[t];
                if (p < SLOTS && wins(p, q)) begin
                    tree[t] = q;
                    q = p;
                end
                t = t / 2;
            end
            tree[0] = q;
        endfunction

        function void push(bit [15:0] k, bit eor, bit dn);
            out_item_t r;
            r.out_key = eor ? 16'h0 : k;
            r.end_of_run = eor;
            r.done_res = dn;
            pending.push_back(r);
        endfunction

        function void note_key(in_item_t it);
            int s;
            int w;
            bit [15:0] k;
            bit [15:0] em;
            k = it.key;
            if (fill < SLOTS) begin
                s = SLOTS - 1 - fill;
                slot_key[s] = k;
                slot_tag[s] = cur_tag;
                slot_emp[s] = 1'b0;
                fill++;
                replay(s);
                if (!it.last) return;
                while (fill < SLOTS) begin
                    s = SLOTS - 1 - fill;
                    slot_key[s] = '0;
                    slot_tag[s] = cur_tag;
                    slot_emp[s] = 1'b1;
                    fill++;
                    replay(s);
                end
            end else begin
                w = tree[0] % SLOTS;
                if (!slot_emp[w]) begin
                    em = slot_key[w];
                    if (slot_tag[w] != cur_tag) begin
                        push('0, 1'b1, 1'b0);
                        cur_tag = ~cur_tag;
                    end
                    push(em, 1'b0, 1'b0);
                    slot_key[w] = k;
                    slot_emp[w] = 1'b0;
                    slot_tag[w] = (k < em) ? ~cur_tag : cur_tag;
                    replay(w);
                end
                if (!it.last) return;
            end
            forever begin
                w = tree[0] % SLOTS;
                if (slot_emp[w]) break;
                if (slot_tag[w] != cur_tag) begin
                    push('0, 1'b1, 1'b0);
                    cur_tag = ~cur_tag;
                end
                push(slot_key[w], 1'b0, 1'b0);
                slot_emp[w] = 1'b1;
                slot_key[w] = '0;
                replay(w);
            end
            push('0, 1'b1, 1'b1);
            clear();
        endfunction

        function bit check_result(out_item_t got, output string msg);
            out_item_t exp;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected result key=%0d eor=%0b done=%0b",
                                got.out_key, got.end_of_run, got.done_res);
                return 1'b0;
            end
            exp = pending.pop_front();
            if (got.end_of_run) markers++; else records++;
            if (got.done_res) files++;
            if (got.end_of_run !== exp.end_of_run || got.done_res !== exp.done_res ||
                (!exp.end_of_run && got.out_key !== exp.out_key)) begin
                msg = $sformatf("got key=%0d eor=%0b done=%0b, expected key=%0d eor=%0b done=%0b",
                                got.out_key, got.end_of_run, got.done_res,
                                exp.out_key, exp.end_of_run, exp.done_res);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    localparam int WATCHDOG = 20000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    run_scoreboard sb;
    int  fails;
    int  idle_cycles;
    bit  quiet;
    int  sent;

    replacement_selection_run_generator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task automatic send_key(bit [15:0] k, bit last);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{key: k, last: last};
        do @(posedge aclk); while (!s_ready);
        sb.note_key('{key: k, last: last});
        sent++;
    endtask

    task automatic send_file(int len, int mode);
        bit [15:0] k;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: k = 16'($urandom);
                1: k = i[15:0] * 16'd37;
                2: k = 16'hFFFF - i[15:0];
                default: k = 16'($urandom_range(0, 7));
            endcase
            send_key(k, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        string msg;
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_result(m_data, msg)) report(msg);
        end
    end

    initial begin
        int burst;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                burst = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        sb = new();
        quiet = 1'b0;
        sent = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single key, short file, extremes, ties, descending order.
        send_key(16'hFFFF, 1'b1);
        send_key(16'h0000, 1'b0);
        send_key(16'hFFFF, 1'b0);
        send_key(16'h5555, 1'b1);
        send_file(12, 2);
        wait_drained();
        send_file(10, 3);
        send_key(16'hAAAA, 1'b0);
        send_key(16'h0000, 1'b1);

        // Random: mostly full-length files, some short ones.
        while (sent < 150) begin
            if (sent > 120) quiet = 1'b1;
            case ($urandom_range(0, 5))
                0: send_file($urandom_range(1, SLOTS), 0);
                1: send_file($urandom_range(9, 30), 1);
                2: send_file($urandom_range(9, 30), 3);
                default: send_file($urandom_range(9, 30), 0);
            endcase
            if (!quiet && $urandom_range(0, 4) == 0) wait_drained();
        end
        wait_drained();

        $display("Sent %0d keys in files of varied length; checked %0d records, %0d markers,",
                 sent, sb.records, sb.markers);
        $display("and %0d completed files.", sb.files);
        if (fails == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* replacement_selection_run_generator_core.f */
sv/rsrg_pkg.sv
sv/rsrg_front.sv
sv/rsrg_back.sv
sv/replacement_selection_run_generator_core.sv
tb/tb_top.sv
